// File: rtl/mqll_pkg.sv
`default_nettype none
// mqll_pkg: shared types and constants of the linked-list queue manager.
// No dependencies; used by mqll_store and multi_queue_linked_list_manager_top.
package mqll_pkg;

  localparam int NODE_FW    = 11;
  localparam int QUEUE_FW   = 7;
  localparam int OP_W       = 3;
  localparam int STATUS_W   = 2;
  localparam int NCOUNT_FW  = 11;
  localparam int QCOUNT_FW  = 8;
  localparam int CFG_DATA_W = 11;

  localparam int PAIR_FIRST  = 1;
  localparam int PAIR_SECOND = 0;

  localparam int PLAN_DEPTH = 3;
  localparam int PLAN_IW    = $clog2(PLAN_DEPTH);

  localparam logic CFG_NODE_COUNT  = 1'b0;
  localparam logic CFG_QUEUE_COUNT = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_FRONT_TO_BACK = 3'd0,
    OP_BACK_TO_FRONT = 3'd1,
    OP_SPLICE_BEFORE = 3'd2,
    OP_SPLICE_AFTER  = 3'd3,
    OP_READ          = 3'd4,
    OP_INIT          = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_NO_EFFECT = 2'd1,
    STATUS_INVALID   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QREAD,
    ST_NREAD,
    ST_WRITE,
    ST_INIT,
    ST_RPT_RD,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic q_re;
    logic q_we;
    logic n_re;
    logic n_we_next;
    logic n_we_prev;
  } mem_ctl_t;

endpackage
`default_nettype wire

// File: rtl/mqll_store.sv
`default_nettype none
// mqll_store: queue RAM (head, tail) with two read ports and node RAM (next, prev)
// with per-field write enables; registered reads. Depends on mqll_pkg.
module mqll_store
  import mqll_pkg::*;
#(
  parameter int NODE_POOL   = 1024,
  parameter int QUEUE_SLOTS = 128
) (
  input  wire                            clk,
  input  wire mem_ctl_t                  ctl,
  input  wire [$clog2(QUEUE_SLOTS)-1:0]  q_raddr_a,
  input  wire [$clog2(QUEUE_SLOTS)-1:0]  q_raddr_b,
  input  wire [$clog2(QUEUE_SLOTS)-1:0]  q_waddr,
  input  wire [1:0][$clog2(NODE_POOL+1)-1:0] q_wdata,
  input  wire [$clog2(NODE_POOL+1)-1:0]  n_raddr,
  input  wire [$clog2(NODE_POOL+1)-1:0]  n_waddr,
  input  wire [1:0][$clog2(NODE_POOL+1)-1:0] n_wdata,
  output logic [1:0][$clog2(NODE_POOL+1)-1:0] q_rdata_a,
  output logic [1:0][$clog2(NODE_POOL+1)-1:0] q_rdata_b,
  output logic [1:0][$clog2(NODE_POOL+1)-1:0] n_rdata
);

  localparam int NW = $clog2(NODE_POOL + 1);

  logic [1:0][NW-1:0] queue_mem [QUEUE_SLOTS];
  logic [1:0][NW-1:0] node_mem  [NODE_POOL + 1];

  always_ff @(posedge clk) begin
    if (ctl.q_we) begin
      queue_mem[q_waddr] <= q_wdata;
    end
    if (ctl.q_re) begin
      q_rdata_a <= queue_mem[q_raddr_a];
      q_rdata_b <= queue_mem[q_raddr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.n_we_next) begin
      node_mem[n_waddr][PAIR_FIRST] <= n_wdata[PAIR_FIRST];
    end
    if (ctl.n_we_prev) begin
      node_mem[n_waddr][PAIR_SECOND] <= n_wdata[PAIR_SECOND];
    end
    if (ctl.n_re) begin
      n_rdata <= node_mem[n_raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/multi_queue_linked_list_manager_top.sv
`default_nettype none
// Linked-list queue manager top: request sequencer and config; uses mqll_pkg, mqll_store.
// Steps to out_strobe: none for read or rejected requests; queue RAM read for no-effect;
// queue RAM read, 3 write slots, report read for splices; single-node moves add a node RAM
// read after the queue RAM read. The next request is taken in the cycle its result is shown.
// Initialize: one node/queue RAM write per cycle.
// Sync active-low reset clears control and loads config defaults; RAM contents undefined until initialize.
module multi_queue_linked_list_manager_top
  import mqll_pkg::*;
#(
  parameter int NODE_POOL   = 1024,
  parameter int QUEUE_SLOTS = 128
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  output logic                  busy,
  input  wire [OP_W-1:0]        in_operation,
  input  wire [QUEUE_FW-1:0]    in_source_queue,
  input  wire [QUEUE_FW-1:0]    in_target_queue,
  input  wire [NODE_FW-1:0]     in_probe_node,
  output logic                  out_strobe,
  output logic [STATUS_W-1:0]   out_status,
  output logic [NODE_FW-1:0]    out_moved_node,
  output logic [NODE_FW-1:0]    out_source_head,
  output logic [NODE_FW-1:0]    out_source_tail,
  output logic [NODE_FW-1:0]    out_target_head,
  output logic [NODE_FW-1:0]    out_target_tail,
  output logic [NODE_FW-1:0]    out_probe_next,
  output logic [NODE_FW-1:0]    out_probe_prev,
  input  wire                   cfg_write,
  input  wire                   cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int NW     = $clog2(NODE_POOL + 1);
  localparam int QW     = $clog2(QUEUE_SLOTS);
  localparam int QCW    = $clog2(QUEUE_SLOTS + 1);
  localparam int LAST   = (NODE_POOL > QUEUE_SLOTS - 1) ? NODE_POOL : QUEUE_SLOTS - 1;
  localparam int CW     = $clog2(LAST + 1);
  localparam int NC_RST = (1024 > NODE_POOL) ? NODE_POOL : 1024;
  localparam int QC_RST = (128 > QUEUE_SLOTS) ? QUEUE_SLOTS : 128;

  typedef logic [NW-1:0] node_id_t;

  typedef struct packed {
    node_id_t addr;
    logic     we_next;
    node_id_t next;
    logic     we_prev;
    node_id_t prev;
  } node_wr_t;

  typedef struct packed {
    logic          we;
    logic [QW-1:0] addr;
    node_id_t      head;
    node_id_t      tail;
  } queue_wr_t;

  function automatic node_wr_t mk_node_wr(node_id_t addr, logic we_next, node_id_t next,
                                          logic we_prev, node_id_t prev);
    node_wr_t w;
    w.addr    = addr;
    w.we_next = we_next && (addr != '0);
    w.next    = next;
    w.we_prev = we_prev && (addr != '0);
    w.prev    = prev;
    return w;
  endfunction

  function automatic queue_wr_t mk_queue_wr(logic we, logic [QW-1:0] addr, node_id_t head,
                                            node_id_t tail);
    queue_wr_t w;
    w.we   = we;
    w.addr = addr;
    w.head = head;
    w.tail = tail;
    return w;
  endfunction

  state_t               state_r, state_nxt;
  op_t                  op_r, op_nxt;
  logic [QUEUE_FW-1:0]  sq_r, sq_nxt, tq_r, tq_nxt;
  logic                 s_ok_r, s_ok_nxt, t_ok_r, t_ok_nxt, p_ok_r, p_ok_nxt;
  node_id_t             probe_r, probe_nxt;
  node_id_t             n_r, n_nxt;
  node_id_t             moved_r, moved_nxt;
  status_t              status_r, status_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [PLAN_IW-1:0]   wr_idx_r, wr_idx_nxt;
  node_wr_t             nplan_r [PLAN_DEPTH];
  node_wr_t             nplan_nxt [PLAN_DEPTH];
  queue_wr_t            qplan_r [PLAN_DEPTH];
  queue_wr_t            qplan_nxt [PLAN_DEPTH];
  node_id_t             node_count_r, node_count_nxt;
  logic [QCW-1:0]       queue_count_r, queue_count_nxt;

  mem_ctl_t             mem_ctl;
  logic [QW-1:0]        q_raddr_a, q_raddr_b, q_waddr;
  logic [1:0][NW-1:0]   q_wdata, q_rdata_a, q_rdata_b;
  node_id_t             n_raddr, n_waddr;
  logic [1:0][NW-1:0]   n_wdata, n_rdata;
  logic                 req_accept;

  mqll_store #(
    .NODE_POOL   (NODE_POOL),
    .QUEUE_SLOTS (QUEUE_SLOTS)
  ) u_store (
    .clk       (clk),
    .ctl       (mem_ctl),
    .q_raddr_a (q_raddr_a),
    .q_raddr_b (q_raddr_b),
    .q_waddr   (q_waddr),
    .q_wdata   (q_wdata),
    .n_raddr   (n_raddr),
    .n_waddr   (n_waddr),
    .n_wdata   (n_wdata),
    .q_rdata_a (q_rdata_a),
    .q_rdata_b (q_rdata_b),
    .n_rdata   (n_rdata)
  );

  assign busy       = !(state_r == ST_IDLE || state_r == ST_REPORT);
  assign req_accept = start && !busy;

  // config writes, clamped into range
  always_comb begin
    node_count_nxt  = node_count_r;
    queue_count_nxt = queue_count_r;
    if (cfg_write) begin
      unique case (cfg_index)
        CFG_NODE_COUNT: begin
          if (cfg_wdata[NCOUNT_FW-1:0] == '0) begin
            node_count_nxt = NW'(1);
          end else if (32'(cfg_wdata[NCOUNT_FW-1:0]) > NODE_POOL) begin
            node_count_nxt = NW'(NODE_POOL);
          end else begin
            node_count_nxt = NW'(cfg_wdata[NCOUNT_FW-1:0]);
          end
        end
        CFG_QUEUE_COUNT: begin
          if (cfg_wdata[QCOUNT_FW-1:0] == '0) begin
            queue_count_nxt = QCW'(1);
          end else if (32'(cfg_wdata[QCOUNT_FW-1:0]) > QUEUE_SLOTS) begin
            queue_count_nxt = QCW'(QUEUE_SLOTS);
          end else begin
            queue_count_nxt = QCW'(cfg_wdata[QCOUNT_FW-1:0]);
          end
        end
      endcase
    end
  end

  always_comb begin
    node_id_t hs, ts, ht, tt, nx, pv, n_sel;
    node_id_t hs_n, ts_n, ht_e, tt_e, ht_n, tt_n;
    logic     same, s_ok_in, t_ok_in, p_ok_in;

    hs      = q_rdata_a[PAIR_FIRST];
    ts      = q_rdata_a[PAIR_SECOND];
    ht      = q_rdata_b[PAIR_FIRST];
    tt      = q_rdata_b[PAIR_SECOND];
    nx      = n_rdata[PAIR_FIRST];
    pv      = n_rdata[PAIR_SECOND];
    same    = (sq_r == tq_r);
    n_sel   = '0;
    hs_n    = '0;
    ts_n    = '0;
    ht_e    = '0;
    tt_e    = '0;
    ht_n    = '0;
    tt_n    = '0;
    s_ok_in = 32'(in_source_queue) < 32'(queue_count_r);
    t_ok_in = 32'(in_target_queue) < 32'(queue_count_r);
    p_ok_in = (in_probe_node != '0) && (32'(in_probe_node) <= NODE_POOL);

    state_nxt  = state_r;
    op_nxt     = op_r;
    sq_nxt     = sq_r;
    tq_nxt     = tq_r;
    s_ok_nxt   = s_ok_r;
    t_ok_nxt   = t_ok_r;
    p_ok_nxt   = p_ok_r;
    probe_nxt  = probe_r;
    n_nxt      = n_r;
    moved_nxt  = moved_r;
    status_nxt = status_r;
    cnt_nxt    = cnt_r;
    wr_idx_nxt = wr_idx_r;
    nplan_nxt  = nplan_r;
    qplan_nxt  = qplan_r;

    mem_ctl   = '0;
    q_raddr_a = QW'(sq_r);
    q_raddr_b = QW'(tq_r);
    n_raddr   = probe_r;
    q_waddr   = qplan_r[wr_idx_r].addr;
    q_wdata[PAIR_FIRST]  = qplan_r[wr_idx_r].head;
    q_wdata[PAIR_SECOND] = qplan_r[wr_idx_r].tail;
    n_waddr   = nplan_r[wr_idx_r].addr;
    n_wdata[PAIR_FIRST]  = nplan_r[wr_idx_r].next;
    n_wdata[PAIR_SECOND] = nplan_r[wr_idx_r].prev;

    unique case (state_r)
      ST_IDLE: begin
      end
      ST_REPORT: begin
        state_nxt = ST_IDLE;
      end
      ST_QREAD: begin
        wr_idx_nxt = '0;
        unique case (op_r) inside
          OP_FRONT_TO_BACK, OP_BACK_TO_FRONT: begin
            n_sel = (op_r == OP_FRONT_TO_BACK) ? hs : ts;
            if (n_sel == '0) begin
              status_nxt = STATUS_NO_EFFECT;
              state_nxt  = ST_REPORT;
            end else begin
              n_nxt       = n_sel;
              mem_ctl.n_re = 1'b1;
              n_raddr     = n_sel;
              state_nxt   = ST_NREAD;
            end
          end
          OP_SPLICE_BEFORE, OP_SPLICE_AFTER: begin
            if (same || hs == '0) begin
              status_nxt = STATUS_NO_EFFECT;
              state_nxt  = ST_REPORT;
            end else begin
              qplan_nxt[0] = mk_queue_wr(1'b1, QW'(sq_r), '0, '0);
              qplan_nxt[2] = mk_queue_wr(1'b0, '0, '0, '0);
              nplan_nxt[0] = mk_node_wr('0, 1'b0, '0, 1'b0, '0);
              nplan_nxt[1] = mk_node_wr('0, 1'b0, '0, 1'b0, '0);
              nplan_nxt[2] = mk_node_wr('0, 1'b0, '0, 1'b0, '0);
              if (ht == '0) begin
                qplan_nxt[1] = mk_queue_wr(1'b1, QW'(tq_r), hs, ts);
              end else if (op_r == OP_SPLICE_BEFORE) begin
                qplan_nxt[1] = mk_queue_wr(1'b1, QW'(tq_r), hs, tt);
                nplan_nxt[0] = mk_node_wr(ts, 1'b1, ht, 1'b0, '0);
                nplan_nxt[1] = mk_node_wr(ht, 1'b0, '0, 1'b1, ts);
              end else begin
                qplan_nxt[1] = mk_queue_wr(1'b1, QW'(tq_r), ht, ts);
                nplan_nxt[0] = mk_node_wr(tt, 1'b1, hs, 1'b0, '0);
                nplan_nxt[1] = mk_node_wr(hs, 1'b0, '0, 1'b1, tt);
              end
              state_nxt = ST_WRITE;
            end
          end
          default: begin
            state_nxt = ST_REPORT;
          end
        endcase
      end
      ST_NREAD: begin
        if (op_r == OP_FRONT_TO_BACK) begin
          hs_n = nx;
          ts_n = (nx == '0) ? '0 : ts;
          ht_e = same ? hs_n : ht;
          tt_e = same ? ts_n : tt;
          ht_n = (tt_e == '0) ? n_r : ht_e;
          tt_n = n_r;
          nplan_nxt[0] = mk_node_wr(n_r, 1'b1, '0, tt_e != '0, tt_e);
          nplan_nxt[1] = mk_node_wr(nx, 1'b0, '0, 1'b1, '0);
          nplan_nxt[2] = mk_node_wr(tt_e, 1'b1, n_r, 1'b0, '0);
        end else begin
          ts_n = pv;
          hs_n = (pv == '0) ? '0 : hs;
          ht_e = same ? hs_n : ht;
          tt_e = same ? ts_n : tt;
          ht_n = n_r;
          tt_n = (ht_e == '0) ? n_r : tt_e;
          nplan_nxt[0] = mk_node_wr(n_r, ht_e != '0, ht_e, 1'b1, '0);
          nplan_nxt[1] = mk_node_wr(pv, 1'b1, '0, 1'b0, '0);
          nplan_nxt[2] = mk_node_wr(ht_e, 1'b0, '0, 1'b1, n_r);
        end
        qplan_nxt[0] = mk_queue_wr(1'b1, QW'(sq_r), hs_n, ts_n);
        qplan_nxt[1] = mk_queue_wr(1'b1, QW'(tq_r), ht_n, tt_n);
        qplan_nxt[2] = mk_queue_wr(1'b0, '0, '0, '0);
        moved_nxt  = n_r;
        wr_idx_nxt = '0;
        state_nxt  = ST_WRITE;
      end
      ST_WRITE: begin
        // slots issue in order; same-queue moves rely on the target slot landing last
        mem_ctl.q_we      = qplan_r[wr_idx_r].we;
        mem_ctl.n_we_next = nplan_r[wr_idx_r].we_next;
        mem_ctl.n_we_prev = nplan_r[wr_idx_r].we_prev;
        if (wr_idx_r == PLAN_IW'(PLAN_DEPTH - 1)) begin
          state_nxt = ST_RPT_RD;
        end else begin
          wr_idx_nxt = wr_idx_r + PLAN_IW'(1);
        end
      end
      ST_INIT: begin
        if (cnt_r != '0 && 32'(cnt_r) <= NODE_POOL) begin
          mem_ctl.n_we_next = 1'b1;
          mem_ctl.n_we_prev = 1'b1;
          n_waddr = NW'(cnt_r);
          n_wdata[PAIR_FIRST] = (32'(cnt_r) < 32'(node_count_r)) ?
                                NW'(cnt_r + CW'(1)) : '0;
          n_wdata[PAIR_SECOND] = (32'(cnt_r) >= 2 && 32'(cnt_r) <= 32'(node_count_r)) ?
                                 NW'(cnt_r - CW'(1)) : '0;
        end
        if (32'(cnt_r) < QUEUE_SLOTS) begin
          mem_ctl.q_we = 1'b1;
          q_waddr = QW'(cnt_r);
          q_wdata[PAIR_FIRST]  = (cnt_r == '0) ? NW'(1) : '0;
          q_wdata[PAIR_SECOND] = (cnt_r == '0) ? node_count_r : '0;
        end
        if (32'(cnt_r) == LAST) begin
          state_nxt = ST_RPT_RD;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      ST_RPT_RD: begin
        mem_ctl.q_re = 1'b1;
        mem_ctl.n_re = 1'b1;
        state_nxt    = ST_REPORT;
      end
    endcase

    if (req_accept) begin
      op_nxt     = op_t'(in_operation);
      sq_nxt     = in_source_queue;
      tq_nxt     = in_target_queue;
      s_ok_nxt   = s_ok_in;
      t_ok_nxt   = t_ok_in;
      p_ok_nxt   = p_ok_in;
      probe_nxt  = NW'(in_probe_node);
      moved_nxt  = '0;
      status_nxt = STATUS_DONE;
      mem_ctl.q_re = 1'b1;
      mem_ctl.n_re = 1'b1;
      q_raddr_a  = QW'(in_source_queue);
      q_raddr_b  = QW'(in_target_queue);
      n_raddr    = NW'(in_probe_node);
      unique case (op_t'(in_operation)) inside
        OP_INIT: begin
          cnt_nxt   = '0;
          state_nxt = ST_INIT;
        end
        OP_READ: begin
          if (!(s_ok_in && t_ok_in)) begin
            status_nxt = STATUS_INVALID;
          end
          state_nxt = ST_REPORT;
        end
        OP_FRONT_TO_BACK, OP_BACK_TO_FRONT, OP_SPLICE_BEFORE, OP_SPLICE_AFTER: begin
          if (s_ok_in && t_ok_in) begin
            state_nxt = ST_QREAD;
          end else begin
            status_nxt = STATUS_INVALID;
            state_nxt  = ST_REPORT;
          end
        end
        default: begin
          status_nxt = STATUS_INVALID;
          state_nxt  = ST_REPORT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cnt_r         <= '0;
      wr_idx_r      <= '0;
      node_count_r  <= NW'(NC_RST);
      queue_count_r <= QCW'(QC_RST);
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      wr_idx_r      <= wr_idx_nxt;
      node_count_r  <= node_count_nxt;
      queue_count_r <= queue_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    sq_r     <= sq_nxt;
    tq_r     <= tq_nxt;
    s_ok_r   <= s_ok_nxt;
    t_ok_r   <= t_ok_nxt;
    p_ok_r   <= p_ok_nxt;
    probe_r  <= probe_nxt;
    n_r      <= n_nxt;
    moved_r  <= moved_nxt;
    status_r <= status_nxt;
    nplan_r  <= nplan_nxt;
    qplan_r  <= qplan_nxt;
  end

  assign out_strobe      = (state_r == ST_REPORT);
  assign out_status      = status_r;
  assign out_moved_node  = NODE_FW'(moved_r);
  assign out_source_head = s_ok_r ? NODE_FW'(q_rdata_a[PAIR_FIRST]) : '0;
  assign out_source_tail = s_ok_r ? NODE_FW'(q_rdata_a[PAIR_SECOND]) : '0;
  assign out_target_head = t_ok_r ? NODE_FW'(q_rdata_b[PAIR_FIRST]) : '0;
  assign out_target_tail = t_ok_r ? NODE_FW'(q_rdata_b[PAIR_SECOND]) : '0;
  assign out_probe_next  = p_ok_r ? NODE_FW'(n_rdata[PAIR_FIRST]) : '0;
  assign out_probe_prev  = p_ok_r ? NODE_FW'(n_rdata[PAIR_SECOND]) : '0;

`ifndef ASSERT_OFF
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_strobe || busy))
    else $error("accepted request neither reported nor in progress");

  a_busy_ends_in_report: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("sequencer left busy without a report");

  a_moved_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_moved_node != '0) |-> (out_status == STATUS_DONE))
    else $error("moved node reported with non-done status");

  a_no_null_node_write: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_ctl.n_we_next || mem_ctl.n_we_prev) |-> (n_waddr != '0))
    else $error("write to null node entry");
`endif

endmodule
`default_nettype wire

// File: bench/tb_top.sv
// tb_top: self-checking bench for multi_queue_linked_list_manager_top.
// Predicts every result with its own copy of the queue and link tables.
// Depends on mqll_pkg and the RTL under rtl/.
module tb_top;
  import mqll_pkg::*;

  localparam int NODE_POOL   = 1024;
  localparam int QUEUE_SLOTS = 128;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct {
    status_t             status;
    logic [NODE_FW-1:0]  moved;
    logic [NODE_FW-1:0]  source_head;
    logic [NODE_FW-1:0]  source_tail;
    logic [NODE_FW-1:0]  target_head;
    logic [NODE_FW-1:0]  target_tail;
    logic [NODE_FW-1:0]  probe_next;
    logic [NODE_FW-1:0]  probe_prev;
  } queue_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [OP_W-1:0]       in_operation = '0;
  logic [QUEUE_FW-1:0]   in_source_queue = '0;
  logic [QUEUE_FW-1:0]   in_target_queue = '0;
  logic [NODE_FW-1:0]    in_probe_node = '0;
  logic                  out_strobe;
  logic [STATUS_W-1:0]   out_status;
  logic [NODE_FW-1:0]    out_moved_node;
  logic [NODE_FW-1:0]    out_source_head;
  logic [NODE_FW-1:0]    out_source_tail;
  logic [NODE_FW-1:0]    out_target_head;
  logic [NODE_FW-1:0]    out_target_tail;
  logic [NODE_FW-1:0]    out_probe_next;
  logic [NODE_FW-1:0]    out_probe_prev;
  logic                  cfg_write = 1'b0;
  logic                  cfg_index = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int head_of [QUEUE_SLOTS];
  int tail_of [QUEUE_SLOTS];
  int next_of [NODE_POOL+1];
  int prev_of [NODE_POOL+1];
  int node_total  = NODE_POOL;
  int queue_total = QUEUE_SLOTS;

  queue_report_t pending_reports[$];
  int failures = 0;
  int max_gap = 14;

  multi_queue_linked_list_manager_top #(
    .NODE_POOL   (NODE_POOL),
    .QUEUE_SLOTS (QUEUE_SLOTS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_source_queue (in_source_queue),
    .in_target_queue (in_target_queue),
    .in_probe_node   (in_probe_node),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_moved_node  (out_moved_node),
    .out_source_head (out_source_head),
    .out_source_tail (out_source_tail),
    .out_target_head (out_target_head),
    .out_target_tail (out_target_tail),
    .out_probe_next  (out_probe_next),
    .out_probe_prev  (out_probe_prev),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

  function automatic int clamp_count(int value, int ceiling);
    if (value < 1) return 1;
    if (value > ceiling) return ceiling;
    return value;
  endfunction

  function automatic void link_nodes(int a, int b);
    if (a >= 1 && a <= NODE_POOL) next_of[a] = b;
    if (b >= 1 && b <= NODE_POOL) prev_of[b] = a;
  endfunction

  // Applies one request to the shadow tables and returns the report it yields.
  function automatic queue_report_t apply_operation(logic [OP_W-1:0] op, int s, int t, int p);
    queue_report_t r;
    bit s_ok;
    bit t_ok;
    int n;
    s_ok = s < queue_total;
    t_ok = t < queue_total;
    r.status = STATUS_DONE;
    r.moved  = '0;
    if (op == OP_INIT) begin
      foreach (head_of[k]) begin
        head_of[k] = 0;
        tail_of[k] = 0;
      end
      foreach (next_of[k]) begin
        next_of[k] = 0;
        prev_of[k] = 0;
      end
      for (int k = 1; k < node_total; k++) link_nodes(k, k + 1);
      head_of[0] = 1;
      tail_of[0] = node_total;
    end else if (op > OP_INIT || !s_ok || !t_ok) begin
      r.status = STATUS_INVALID;
    end else begin
      case (op) inside
        OP_FRONT_TO_BACK: begin
          n = head_of[s];
          if (n == 0) begin
            r.status = STATUS_NO_EFFECT;
          end else begin
            head_of[s] = next_of[n];
            next_of[n] = 0;
            if (head_of[s] != 0) prev_of[head_of[s]] = 0;
            else tail_of[s] = 0;
            if (tail_of[t] == 0) begin
              head_of[t] = n;
              tail_of[t] = n;
            end else begin
              link_nodes(tail_of[t], n);
              tail_of[t] = n;
            end
            r.moved = NODE_FW'(n);
          end
        end
        OP_BACK_TO_FRONT: begin
          n = tail_of[s];
          if (n == 0) begin
            r.status = STATUS_NO_EFFECT;
          end else begin
            tail_of[s] = prev_of[n];
            prev_of[n] = 0;
            if (tail_of[s] != 0) next_of[tail_of[s]] = 0;
            else head_of[s] = 0;
            if (head_of[t] == 0) begin
              head_of[t] = n;
              tail_of[t] = n;
            end else begin
              link_nodes(n, head_of[t]);
              head_of[t] = n;
            end
            r.moved = NODE_FW'(n);
          end
        end
        OP_SPLICE_BEFORE, OP_SPLICE_AFTER: begin
          if (s == t || head_of[s] == 0) begin
            r.status = STATUS_NO_EFFECT;
          end else begin
            if (head_of[t] == 0) begin
              head_of[t] = head_of[s];
              tail_of[t] = tail_of[s];
            end else if (op == OP_SPLICE_BEFORE) begin
              link_nodes(tail_of[s], head_of[t]);
              head_of[t] = head_of[s];
            end else begin
              link_nodes(tail_of[t], head_of[s]);
              tail_of[t] = tail_of[s];
            end
            head_of[s] = 0;
            tail_of[s] = 0;
          end
        end
        default: ;
      endcase
    end
    r.source_head = s_ok ? NODE_FW'(head_of[s]) : '0;
    r.source_tail = s_ok ? NODE_FW'(tail_of[s]) : '0;
    r.target_head = t_ok ? NODE_FW'(head_of[t]) : '0;
    r.target_tail = t_ok ? NODE_FW'(tail_of[t]) : '0;
    r.probe_next  = (p >= 1 && p <= NODE_POOL) ? NODE_FW'(next_of[p]) : '0;
    r.probe_prev  = (p >= 1 && p <= NODE_POOL) ? NODE_FW'(prev_of[p]) : '0;
    return r;
  endfunction

  task automatic report_failure(string msg);
    failures++;
    if (failures <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(string name, logic [NODE_FW-1:0] want, logic [NODE_FW-1:0] got);
    if (got !== want)
      report_failure($sformatf("%s expected %0d got %0d", name, want, got));
  endtask

  always @(posedge clk) begin : check_results
    queue_report_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_reports.size() == 0) begin
        report_failure("result with no request outstanding");
      end else begin
        want = pending_reports[0];
        pending_reports.delete(0);
        check_field("status", NODE_FW'(want.status), NODE_FW'(out_status));
        check_field("moved_node", want.moved, out_moved_node);
        check_field("source_head", want.source_head, out_source_head);
        check_field("source_tail", want.source_tail, out_source_tail);
        check_field("target_head", want.target_head, out_target_head);
        check_field("target_tail", want.target_tail, out_target_tail);
        check_field("probe_next", want.probe_next, out_probe_next);
        check_field("probe_prev", want.probe_prev, out_probe_prev);
      end
    end
  end

  // start stays high after acceptance; it drops at the next falling edge
  // unless another request follows with no gap
  task automatic issue_request(logic [OP_W-1:0] op, int s, int t, int p);
    int gap;
    gap = $urandom_range(0, max_gap);
    @(negedge clk);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start           <= 1'b1;
    in_operation    <= op;
    in_source_queue <= QUEUE_FW'(s);
    in_target_queue <= QUEUE_FW'(t);
    in_probe_node   <= NODE_FW'(p);
    do @(posedge clk); while (busy);
    pending_reports.insert(pending_reports.size(), apply_operation(op, s, t, p));
  endtask

  task automatic wait_all_reported();
    @(negedge clk);
    start <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_register(logic idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    start     <= 1'b0;
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_NODE_COUNT) node_total = clamp_count(int'(value), NODE_POOL);
    else queue_total = clamp_count(int'(value[7:0]), QUEUE_SLOTS);
  endtask

  function automatic int pick_queue();
    if ($urandom_range(0, 9) != 0) return $urandom_range(0, queue_total - 1);
    return $urandom_range(0, 127);
  endfunction

  task automatic test_directed_operations();
    max_gap = 14;
    write_register(CFG_NODE_COUNT, 11'd5);
    write_register(CFG_QUEUE_COUNT, 11'd4);
    issue_request(OP_INIT, 0, 1, 1);
    issue_request(OP_FRONT_TO_BACK, 0, 1, 1);
    issue_request(OP_BACK_TO_FRONT, 0, 1, 5);
    issue_request(OP_FRONT_TO_BACK, 0, 0, 2);
    issue_request(OP_BACK_TO_FRONT, 0, 0, 2);
    issue_request(OP_SPLICE_BEFORE, 1, 0, 1);
    issue_request(OP_SPLICE_AFTER, 0, 2, 4);
    issue_request(OP_SPLICE_BEFORE, 1, 2, 3);
    issue_request(OP_SPLICE_AFTER, 2, 2, 3);
    issue_request(OP_FRONT_TO_BACK, 1, 2, 0);
    issue_request(OP_BACK_TO_FRONT, 3, 2, 0);
    issue_request(OP_FRONT_TO_BACK, 2, 3, 5);
    issue_request(OP_SPLICE_AFTER, 2, 3, 5);
    issue_request(OP_FRONT_TO_BACK, 4, 0, 1);
    issue_request(OP_BACK_TO_FRONT, 0, 127, 1);
    issue_request(OP_SPARE_6, 0, 0, 3);
    issue_request(OP_SPARE_7, 127, 127, 2047);
    issue_request(OP_READ, 3, 1, 1024);
    issue_request(OP_READ, 3, 0, 1025);
    issue_request(OP_INIT, 127, 5, 5);
  endtask

  task automatic test_register_extremes();
    wait_all_reported();
    write_register(CFG_NODE_COUNT, 11'd0);
    write_register(CFG_QUEUE_COUNT, 11'd0);
    issue_request(OP_INIT, 0, 0, 1);
    issue_request(OP_FRONT_TO_BACK, 0, 0, 1);
    issue_request(OP_SPLICE_BEFORE, 0, 0, 1);
    issue_request(OP_READ, 1, 0, 2);
    wait_all_reported();
    write_register(CFG_NODE_COUNT, 11'd2047);
    write_register(CFG_QUEUE_COUNT, 11'd255);
    issue_request(OP_INIT, 0, 127, 1024);
    issue_request(OP_BACK_TO_FRONT, 0, 127, 1023);
    issue_request(OP_FRONT_TO_BACK, 127, 0, 1024);
  endtask

  task automatic test_random_traffic();
    int nodes[8]  = '{12, 30, 5, 64, 1024, 200, 3, 2047};
    int queues[8] = '{4, 8, 2, 16, 128, 255, 3, 1};
    int counts[8] = '{150, 150, 110, 120, 60, 120, 70, 50};
    int gaps[8]   = '{14, 0, 14, 14, 0, 14, 14, 0};
    int roll;
    int probe;
    logic [OP_W-1:0] op;
    for (int ph = 0; ph < 8; ph++) begin
      wait_all_reported();
      write_register(CFG_NODE_COUNT, CFG_DATA_W'(nodes[ph]));
      write_register(CFG_QUEUE_COUNT, CFG_DATA_W'(queues[ph]));
      max_gap = gaps[ph];
      issue_request(OP_INIT, 0, 0, 0);
      for (int k = 0; k < counts[ph]; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 32) op = OP_FRONT_TO_BACK;
        else if (roll < 56) op = OP_BACK_TO_FRONT;
        else if (roll < 68) op = OP_SPLICE_BEFORE;
        else if (roll < 80) op = OP_SPLICE_AFTER;
        else if (roll < 90) op = OP_READ;
        else if (roll < 93) op = OP_INIT;
        else op = OP_W'($urandom_range(0, 7));
        if ($urandom_range(0, 99) < 85) probe = $urandom_range(0, node_total + 1);
        else probe = $urandom_range(0, 2047);
        issue_request(op, pick_queue(), pick_queue(), probe);
        if ($urandom_range(0, 49) == 0) wait_all_reported();
      end
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_directed_operations();
    test_register_extremes();
    test_random_traffic();
    wait_all_reported();
    repeat (10) @(posedge clk);
    if (failures == 0 && pending_reports.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// File: filelist.f
rtl/mqll_pkg.sv
rtl/mqll_store.sv
rtl/multi_queue_linked_list_manager_top.sv
bench/tb_top.sv
